[design/assert_macros.svh]
// assert_macros.svh: concurrent assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_IMPL(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) else $error("%m failed");
`else
`define ASSERT_IMPL(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

[design/gbe_pkg.sv]
// ----------------------------------------------------------------------------
// gbe_pkg: shared types and constants of the breeding engine
// Sizes, item kinds and the sequencer states.
// ----------------------------------------------------------------------------
package gbe_pkg;
  localparam int unsigned PopSize     = 64;
  localparam int unsigned GenomeBytes = 1024;
  localparam int unsigned IndW        = 6;
  localparam int unsigned PosW        = 10;
  localparam int unsigned AddrW       = 1 + IndW + PosW;
  localparam int unsigned TotW        = 22;
  localparam int unsigned InW         = 8 * 34;
  localparam int unsigned OutW        = 32;

  typedef enum logic [2:0] {
    KIND_LOAD   = 3'd0,
    KIND_FIT    = 3'd1,
    KIND_BREED  = 3'd2,
    KIND_READ   = 3'd3,
    KIND_COMMIT = 3'd4
  } kind_e;

  typedef enum logic [3:0] {
    ST_IDLE, ST_READ, ST_READ_WAIT, ST_MOD, ST_SCAN, ST_CUT,
    ST_COPY, ST_MUT_RD, ST_MUT_WAIT, ST_MUT_WR, ST_OUT
  } state_e;
endpackage

[design/genetic_breeding_engine.sv]
// ----------------------------------------------------------------------------
// genetic_breeding_engine: roulette selection, crossover and mutation
//
// One input stream (s_axis) carries items of five kinds: load byte, write
// fitness, breed pair, read byte and commit. Breed and read items give one
// result on m_axis; the others give none. Items are handled one at a time
// and s_axis_tready is low while an item is in work or its result waits.
// A breed item runs two spins, where a 32-step shift-subtract unit
// reduces each spin word modulo the total, then builds the children:
// the single-port genome memory alternates a read and a write for each
// copied byte, and one bit of each child is then flipped.
// Reset clears bank select, fitness table and total; the genome memory is
// undefined until loaded. When the receiver stalls the result is held on
// m_axis and no new item is taken.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"
module genetic_breeding_engine (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // kind, individual, byte_index, byte_value, fitness_value, random_mom,
  // random_dad, random_cut, mut_byte_first, mut_bit_first, mut_byte_second,
  // mut_bit_second
  input  logic [gbe_pkg::InW-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // mom_index, dad_index, cut_point, empty_wheel, read_byte
  output logic [gbe_pkg::OutW-1:0] m_axis_tdata
);
  import gbe_pkg::*;

  logic [2:0] in_kind; logic [IndW-1:0] in_ind; logic [PosW-1:0] in_pos;
  logic [7:0] in_byte; logic [15:0] in_fit;
  assign in_kind = s_axis_tdata[2:0];
  assign in_ind  = s_axis_tdata[8:3];
  assign in_pos  = s_axis_tdata[18:9];
  assign in_byte = s_axis_tdata[26:19];
  assign in_fit  = s_axis_tdata[42:27];

  logic [7:0] mem [2**AddrW];
  logic [15:0] fit_q [PopSize];
  logic [15:0] fit_rd_q;
  logic bank_q; logic [TotW-1:0] tot_q;
  state_e st_q, st_d;
  logic [InW-1:0] item_q;
  logic spin_q;                  // 0 mom, 1 dad
  logic [5:0] step_q;            // modulo bit step
  logic [31:0] rem_q;            // remainder / scan target
  logic [TotW:0] sum_q;
  logic [IndW-1:0] x_q, mom_q, dad_q;
  logic empty_q, child_q, phase_q;
  logic [PosW-1:0] i_q, cut_q;
  logic [7:0] rd_q;
  logic outv_q; logic [OutW-1:0] out_q;

  logic mem_we; logic [AddrW-1:0] mem_a; logic [7:0] mem_wd;
  logic acc;
  assign acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (st_q == ST_IDLE) && !outv_q;

  logic [IndW-1:0] q_ind; logic [PosW-1:0] q_pos; logic [31:0] q_rnd;
  logic [IndW-1:0] slot, src; logic [PosW-1:0] mpos; logic [2:0] mbit;
  logic slot_ok;
  assign q_ind   = item_q[8:3];
  assign q_pos   = item_q[18:9];
  assign q_rnd   = spin_q ? item_q[106:75] : item_q[74:43];
  assign slot    = {q_ind[IndW-2:0], child_q};
  assign slot_ok = !q_ind[IndW-1];
  assign src     = ((i_q < cut_q) ^ child_q) ? mom_q : dad_q;
  assign mpos    = child_q ? item_q[212:203] : item_q[148:139];
  assign mbit    = child_q ? item_q[237:235] : item_q[173:171];

  // shared compare/subtract unit
  logic nbit; logic [32:0] trial; logic [TotW:0] nsum; logic scan_done;
  assign nbit  = q_rnd[5'd31 - step_q[4:0]];
  assign trial = {rem_q, nbit} - {11'd0, tot_q};
  assign nsum  = sum_q + {{(TotW-15){1'b0}}, fit_rd_q};
  assign scan_done = (tot_q == '0) || (nsum > {1'b0, rem_q[TotW-1:0]}) ||
                     (x_q == IndW'(PopSize-1));

  always_comb begin
    st_d = st_q; mem_we = 1'b0; mem_wd = 8'd0;
    mem_a = (st_q == ST_IDLE) ? {bank_q, in_ind, in_pos} : {bank_q, q_ind, q_pos};
    unique case (st_q)
      ST_IDLE: if (acc) begin
        case (in_kind)
          KIND_LOAD: begin mem_we = 1'b1; mem_wd = in_byte; end
          KIND_READ: st_d = ST_READ_WAIT;
          KIND_BREED: st_d = ST_MOD;
          default: ;
        endcase
      end
      ST_READ_WAIT: st_d = ST_OUT;
      ST_MOD: if (tot_q == '0 || step_q == 6'd32) st_d = ST_SCAN;
      ST_SCAN: if (scan_done) begin
        if (spin_q) st_d = ST_CUT; else st_d = ST_MOD;
      end
      ST_CUT: st_d = ST_COPY;
      ST_COPY: begin
        if (!phase_q) mem_a = {bank_q, src, i_q};
        else begin
          mem_a = {~bank_q, slot, i_q}; mem_we = slot_ok; mem_wd = rd_q;
          if (i_q == PosW'(GenomeBytes-1)) st_d = ST_MUT_RD;
        end
      end
      ST_MUT_RD: begin mem_a = {~bank_q, slot, mpos}; st_d = ST_MUT_WAIT; end
      ST_MUT_WAIT: begin mem_a = {~bank_q, slot, mpos}; st_d = ST_MUT_WR; end
      ST_MUT_WR: begin
        mem_a = {~bank_q, slot, mpos}; mem_we = slot_ok;
        mem_wd = rd_q ^ (8'd1 << mbit);
        st_d = child_q ? ST_OUT : ST_COPY;
      end
      ST_OUT: st_d = ST_IDLE;
      default: st_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) mem[mem_a] <= mem_wd;
    rd_q <= mem[mem_a];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= ST_IDLE; bank_q <= 1'b0; tot_q <= '0; outv_q <= 1'b0;
      for (int k = 0; k < PopSize; k++) fit_q[k] <= '0;
    end else begin
      st_q <= st_d;
      if (outv_q && m_axis_tready) outv_q <= 1'b0;
      unique case (st_q)
        ST_IDLE: if (acc) begin
          item_q <= s_axis_tdata; spin_q <= 1'b0; step_q <= '0;
          rem_q <= '0; x_q <= '0; sum_q <= '0; empty_q <= 1'b0;
          child_q <= 1'b0; phase_q <= 1'b0; i_q <= '0;
          fit_rd_q <= fit_q[0];
          case (in_kind)
            KIND_FIT: begin
              fit_q[in_ind] <= in_fit;
              if ({1'b0, tot_q} + {7'd0, in_fit} > {1'b0, {TotW{1'b1}}})
                tot_q <= '1;
              else tot_q <= tot_q + TotW'(in_fit);
            end
            KIND_COMMIT: begin bank_q <= ~bank_q; tot_q <= '0; end
            default: ;
          endcase
        end
        ST_READ_WAIT: ;
        ST_MOD: if (tot_q != '0 && step_q != 6'd32) begin
          step_q <= step_q + 6'd1;
          rem_q <= trial[32] ? {rem_q[30:0], nbit} : trial[31:0];
        end
        ST_SCAN: begin
          if (scan_done) begin
            if (tot_q == '0) empty_q <= 1'b1;
            if (spin_q) dad_q <= (tot_q == '0) ? IndW'(PopSize-1) : x_q;
            else mom_q <= (tot_q == '0) ? IndW'(PopSize-1) : x_q;
            spin_q <= 1'b1; step_q <= '0; rem_q <= '0; x_q <= '0; sum_q <= '0;
            fit_rd_q <= fit_q[0];
          end else begin
            sum_q <= nsum; x_q <= x_q + IndW'(1);
            fit_rd_q <= fit_q[x_q + IndW'(1)];
          end
        end
        ST_CUT: cut_q <= item_q[116:107];
        ST_COPY: begin
          phase_q <= ~phase_q;
          if (phase_q) i_q <= i_q + PosW'(1);
        end
        ST_MUT_WR: begin child_q <= 1'b1; i_q <= '0; phase_q <= 1'b0; end
        ST_OUT: begin
          outv_q <= 1'b1;
          if (item_q[2:0] == KIND_READ)
            out_q <= {1'b0, rd_q, 1'b0, 10'd0, 6'd0, 6'd0};
          else out_q <= {1'b0, 8'd0, empty_q, cut_q, dad_q, mom_q};
        end
        default: ;
      endcase
    end
  end

  assign m_axis_tvalid = outv_q;
  assign m_axis_tdata  = out_q;

  `ASSERT_NEVER(a_busy_no_ready, clk_i, rst_ni, s_axis_tready && outv_q)
  `ASSERT_IMPL(a_out_one_cycle, clk_i, rst_ni, (st_q == ST_OUT) |=> outv_q)
  `ASSERT_IMPL(a_idle_after_out, clk_i, rst_ni, (st_q == ST_OUT) |=> (st_q == ST_IDLE))
endmodule
